/* hw/rtl/sha1_pkg.sv */
// sha1_pkg: shared types and constants for the SHA-1 stream hasher.
// No dependencies.
package sha1_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PAD,
    ST_CLR,
    ST_LEN_HI,
    ST_LEN_LO,
    ST_INIT,
    ST_RND,
    ST_RD,
    ST_FIN,
    ST_OUT
  } state_e;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [6:0] LastRound = 7'd79;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
    rotl = (x << n) | (x >> (32 - n));
  endfunction

endpackage

/* hw/rtl/sha1_stream_hasher.sv */
// sha1_stream_hasher: SHA-1 digest over a byte stream.
// Depends on sha1_pkg and sha1_ram (message schedule storage).
//
// Input channel: each transaction carries at most one byte (data_byte_i,
// has_byte_i, end_of_message_i); in_stall_o high means the block is busy.
// Output channel: five transactions per message, digest_word_o h0 first,
// word_index_o 0..4, last_word_o on the fifth.
// Bytes are packed into a 16-word schedule RAM (single port, registered
// read). Each byte is stored by a read-modify-write of its word. A block's
// completion adds a load step, rounds 0..15 (read, update), rounds 16..79
// (reads of w[t-3], w[t-8], w[t-14], w[t-16], then update and write back)
// and a final chain update. End of message adds a merge step, up to 16
// padding writes, two length writes and one compression, or two compressions
// when the length does not fit, then the digest words, one per cycle while
// out_stall_i is low. While the receiver stalls, the current word holds and
// no input is taken.
// Reset (rst_ni low, asynchronous) restores the initial chain value, clears
// the bit count and leaves the block ready for bytes.
module sha1_stream_hasher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        has_byte_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);
  sha1_pkg::state_e state_q, state_d;
  logic [31:0] h_q [5];
  logic [31:0] h_d [5];
  logic [31:0] a_q, b_q, c_q, d_q, e_q;
  logic [31:0] a_d, b_d, c_d, d_d, e_d;
  logic [63:0] cnt_q, cnt_d;
  logic [6:0]  rnd_q, rnd_d;
  logic [3:0]  sub_q, sub_d;
  logic [31:0] w0_q, w0_d, w1_q, w1_d, w2_q, w2_d;
  logic [7:0]  byte_q, byte_d;
  logic        eom_q, eom_d, two_q, two_d, rmw_q, rmw_d;
  logic        fin_q, fin_d;
  logic [2:0]  oidx_q, oidx_d;

  logic        we;
  logic [3:0]  addr;
  logic [31:0] wdata, rdata;

  sha1_ram #(.Width(32), .Depth(16)) u_sched (
    .clk_i  (clk_i),
    .we_i   (we),
    .addr_i (addr),
    .wdata_i(wdata),
    .rdata_o(rdata)
  );

  logic [5:0]  pos;
  logic [31:0] merged, wexp, wt, f, k, tmp;
  logic [1:0]  stg;
  logic [3:0]  s;
  assign pos = cnt_q[8:3];
  assign s = rnd_q[3:0];

  always_comb begin
    merged = (pos[1:0] == 2'd0) ? 32'd0 : rdata;
    merged = merged | ({24'd0, byte_q} << ({3'd0, 2'd3 - pos[1:0]} * 5'd8));
    wexp = sha1_pkg::rotl(w0_q ^ w1_q ^ w2_q ^ rdata, 1);
    wt = (rnd_q < 7'd16) ? rdata : wexp;
    if (rnd_q < 7'd20) stg = 2'd0;
    else if (rnd_q < 7'd40) stg = 2'd1;
    else if (rnd_q < 7'd60) stg = 2'd2;
    else stg = 2'd3;
    unique case (stg)
      2'd0: begin f = (b_q & c_q) | (~b_q & d_q); k = sha1_pkg::K0; end
      2'd1: begin f = b_q ^ c_q ^ d_q; k = sha1_pkg::K1; end
      2'd2: begin f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q); k = sha1_pkg::K2; end
      default: begin f = b_q ^ c_q ^ d_q; k = sha1_pkg::K3; end
    endcase
    tmp = sha1_pkg::rotl(a_q, 5) + f + e_q + wt + k;
  end

  always_comb begin
    state_d = state_q;
    for (int i = 0; i < 5; i++) h_d[i] = h_q[i];
    a_d = a_q; b_d = b_q; c_d = c_q; d_d = d_q; e_d = e_q;
    cnt_d = cnt_q; rnd_d = rnd_q; sub_d = sub_q;
    w0_d = w0_q; w1_d = w1_q; w2_d = w2_q;
    byte_d = byte_q; eom_d = eom_q; two_d = two_q; rmw_d = rmw_q;
    fin_d = fin_q;
    oidx_d = oidx_q;
    we = 1'b0; addr = pos[5:2]; wdata = merged;
    in_stall_o = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      sha1_pkg::ST_IDLE: begin
        in_stall_o = rmw_q;
        if (rmw_q) begin
          we = 1'b1;
          cnt_d = cnt_q + 64'd8;
          rmw_d = 1'b0;
          if (pos == 6'd63) begin
            state_d = sha1_pkg::ST_INIT;
          end else if (eom_q) begin
            state_d = sha1_pkg::ST_PAD;
          end
        end else if (in_valid_i) begin
          byte_d = data_byte_i;
          eom_d = end_of_message_i;
          if (has_byte_i) begin
            rmw_d = 1'b1;
          end else if (end_of_message_i) begin
            state_d = sha1_pkg::ST_PAD;
          end
        end
      end
      sha1_pkg::ST_PAD: begin
        // ram read of pos word was issued; merge 0x80
        byte_d = 8'h80;
        state_d = sha1_pkg::ST_CLR;
        sub_d = pos[5:2];
        two_d = (pos >= 6'd56);
      end
      sha1_pkg::ST_CLR: begin
        we = 1'b1;
        addr = sub_q;
        wdata = (sub_q == pos[5:2]) ? merged : 32'd0;
        sub_d = sub_q + 4'd1;
        if (sub_q == 4'd15) state_d = two_q ? sha1_pkg::ST_INIT : sha1_pkg::ST_LEN_HI;
        // merged read only valid first cycle; byte 0x80 replaces byte_q
        if (sub_q != pos[5:2]) wdata = 32'd0;
      end
      sha1_pkg::ST_LEN_HI: begin
        we = 1'b1; addr = 4'd14; wdata = cnt_q[63:32];
        state_d = sha1_pkg::ST_LEN_LO;
      end
      sha1_pkg::ST_LEN_LO: begin
        we = 1'b1; addr = 4'd15; wdata = cnt_q[31:0];
        eom_d = 1'b0;
        fin_d = 1'b1;
        state_d = sha1_pkg::ST_INIT;
      end
      sha1_pkg::ST_INIT: begin
        a_d = h_q[0]; b_d = h_q[1]; c_d = h_q[2]; d_d = h_q[3]; e_d = h_q[4];
        rnd_d = 7'd0;
        addr = 4'd0;
        state_d = sha1_pkg::ST_RND;
      end
      sha1_pkg::ST_RD: begin
        addr = s;
        state_d = sha1_pkg::ST_RND;
      end
      sha1_pkg::ST_RND: begin
        we = (rnd_q >= 7'd16);
        addr = s;
        wdata = wexp;
        e_d = d_q; d_d = c_q; c_d = sha1_pkg::rotl(b_q, 30); b_d = a_q; a_d = tmp;
        rnd_d = rnd_q + 7'd1;
        state_d = sha1_pkg::ST_FIN;
      end
      sha1_pkg::ST_FIN: begin
        // gather w[s+13], w[s+8], w[s+2] and read w[s] for the next round; after round 79 update the chain
        if (rnd_q == 7'd80) begin
          h_d[0] = h_q[0] + a_q; h_d[1] = h_q[1] + b_q; h_d[2] = h_q[2] + c_q;
          h_d[3] = h_q[3] + d_q; h_d[4] = h_q[4] + e_q;
          rnd_d = 7'd0;
          sub_d = 4'd0;
          if (two_q) begin
            two_d = 1'b0;
            state_d = sha1_pkg::ST_CLR;
            byte_d = 8'h00;
          end else if (eom_q) begin
            state_d = sha1_pkg::ST_PAD;
          end else if (fin_q) begin
            fin_d = 1'b0;
            state_d = sha1_pkg::ST_OUT;
          end else begin
            state_d = sha1_pkg::ST_IDLE;
          end
        end else if (rnd_q < 7'd16) begin
          addr = s;
          state_d = sha1_pkg::ST_RND;
        end else begin
          unique case (sub_q)
            4'd0: begin addr = s + 4'd13; sub_d = 4'd1; end
            4'd1: begin addr = s + 4'd8; w0_d = rdata; sub_d = 4'd2; end
            4'd2: begin addr = s + 4'd2; w1_d = rdata; sub_d = 4'd3; end
            4'd3: begin addr = s; w2_d = rdata; sub_d = 4'd0; state_d = sha1_pkg::ST_RND; end
            default: sub_d = 4'd0;
          endcase
        end
      end
      sha1_pkg::ST_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          oidx_d = oidx_q + 3'd1;
          if (oidx_q == 3'd4) begin
            state_d = sha1_pkg::ST_IDLE;
            oidx_d = 3'd0;
            h_d[0] = sha1_pkg::H0; h_d[1] = sha1_pkg::H1; h_d[2] = sha1_pkg::H2;
            h_d[3] = sha1_pkg::H3; h_d[4] = sha1_pkg::H4;
            cnt_d = 64'd0;
          end
        end
      end
      default: state_d = sha1_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sha1_pkg::ST_IDLE;
      h_q[0] <= sha1_pkg::H0; h_q[1] <= sha1_pkg::H1; h_q[2] <= sha1_pkg::H2;
      h_q[3] <= sha1_pkg::H3; h_q[4] <= sha1_pkg::H4;
      cnt_q <= '0; rnd_q <= '0; sub_q <= '0;
      eom_q <= 1'b0; two_q <= 1'b0; rmw_q <= 1'b0; oidx_q <= '0; fin_q <= 1'b0;
      a_q <= '0; b_q <= '0; c_q <= '0; d_q <= '0; e_q <= '0;
    end else begin
      state_q <= state_d;
      for (int i = 0; i < 5; i++) h_q[i] <= h_d[i];
      cnt_q <= cnt_d; rnd_q <= rnd_d; sub_q <= sub_d;
      eom_q <= eom_d; two_q <= two_d; rmw_q <= rmw_d; oidx_q <= oidx_d; fin_q <= fin_d;
      a_q <= a_d; b_q <= b_d; c_q <= c_d; d_q <= d_d; e_q <= e_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w0_q <= w0_d; w1_q <= w1_d; w2_q <= w2_d; byte_q <= byte_d;
  end

  always_comb begin
    unique case (oidx_q)
      3'd0: digest_word_o = h_q[0];
      3'd1: digest_word_o = h_q[1];
      3'd2: digest_word_o = h_q[2];
      3'd3: digest_word_o = h_q[3];
      default: digest_word_o = h_q[4];
    endcase
  end
  assign word_index_o = oidx_q;
  assign last_word_o = (oidx_q == 3'd4);
endmodule

/* hw/rtl/sha1_ram.sv */
// sha1_ram: generic single-port synchronous RAM with registered read.
// No dependencies.
module sha1_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

/* hw/rtl/sha1_checker.sv */
// sha1_checker: port-level assertions for sha1_stream_hasher.
// Depends on sha1_stream_hasher ports; bound to it below.
module sha1_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] digest_word_o,
  input logic [2:0]  word_index_o,
  input logic        last_word_o
);
  a_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> word_index_o <= 3'd4) else $error("index out of range");
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_word_o == (word_index_o == 3'd4))) else $error("last flag");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(digest_word_o))
    else $error("stalled output changed");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input taken during digest output");
  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_word_o |=> out_valid_o)
    else $error("digest words not contiguous");
endmodule

bind sha1_stream_hasher sha1_checker u_sha1_checker (.*);

/* dv/tb_sha1_stream_hasher.sv */
// tb_sha1_stream_hasher: randomized self-checking testbench for the SHA-1 stream hasher.
// Depends on sha1_pkg and sha1_stream_hasher; predicts digests with an in-bench SHA-1.
module tb_sha1_stream_hasher;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       eom;
  } byte_txn_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_txn_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  data_byte_i;
  logic        has_byte_i;
  logic        end_of_message_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [31:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        last_word_o;

  sha1_stream_hasher DUT (.*);

  byte_txn_t   pending_q[$];
  digest_txn_t digest_q[$];
  int          mismatches;

  logic [31:0] chain_r[5];
  logic [31:0] sched_r[16];
  logic [63:0] bit_cnt_r;

  function automatic logic [31:0] rol(logic [31:0] x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void hasher_reset();
    chain_r = '{sha1_pkg::H0, sha1_pkg::H1, sha1_pkg::H2, sha1_pkg::H3, sha1_pkg::H4};
    foreach (sched_r[i]) sched_r[i] = '0;
    bit_cnt_r = '0;
  endfunction

  function automatic void compress_block();
    logic [31:0] w[16];
    logic [31:0] a, b, c, d, e, f, k, t;
    int s;
    w = sched_r;
    a = chain_r[0]; b = chain_r[1]; c = chain_r[2]; d = chain_r[3]; e = chain_r[4];
    for (int r = 0; r < 80; r++) begin
      s = r % 16;
      if (r >= 16) w[s] = rol(w[(s + 13) % 16] ^ w[(s + 8) % 16] ^ w[(s + 2) % 16] ^ w[s], 1);
      case (r / 20)
        0: begin f = (b & c) | (~b & d); k = sha1_pkg::K0; end
        1: begin f = b ^ c ^ d; k = sha1_pkg::K1; end
        2: begin f = (b & c) | (b & d) | (c & d); k = sha1_pkg::K2; end
        default: begin f = b ^ c ^ d; k = sha1_pkg::K3; end
      endcase
      t = rol(a, 5) + f + e + w[s] + k;
      e = d; d = c; c = rol(b, 30); b = a; a = t;
    end
    chain_r[0] += a; chain_r[1] += b; chain_r[2] += c; chain_r[3] += d; chain_r[4] += e;
  endfunction

  function automatic void place_byte(int pos, logic [7:0] v);
    if (pos % 4 == 0) sched_r[pos / 4] = '0;
    sched_r[pos / 4][(3 - pos % 4) * 8 +: 8] = v;
  endfunction

  function automatic void predict_digest(byte_txn_t t);
    int pos;
    logic [63:0] len;
    digest_txn_t d;
    if (t.has_byte) begin
      pos = int'(bit_cnt_r[8:3]);
      place_byte(pos, t.data_byte);
      bit_cnt_r += 64'd8;
      if (pos == 63) compress_block();
    end
    if (!t.eom) return;
    len = bit_cnt_r;
    pos = int'(bit_cnt_r[8:3]);
    place_byte(pos, 8'h80);
    for (int i = pos / 4 + 1; i < 16; i++) sched_r[i] = '0;
    if (pos >= 56) begin
      compress_block();
      foreach (sched_r[i]) sched_r[i] = '0;
    end
    sched_r[14] = len[63:32];
    sched_r[15] = len[31:0];
    compress_block();
    for (int i = 0; i < 5; i++) begin
      d.word = chain_r[i];
      d.idx = i[2:0];
      d.last = (i == 4);
      digest_q.push_back(d);
    end
    hasher_reset();
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void add_msg(int len, int fixed_val, bit eom_has_byte);
    byte_txn_t t;
    for (int i = 0; i < len; i++) begin
      t.data_byte = (fixed_val >= 0) ? fixed_val[7:0] : 8'($urandom);
      t.has_byte = 1'b1;
      t.eom = eom_has_byte && (i == len - 1);
      if ($urandom_range(0, 19) == 0) pending_q.push_back('{8'($urandom), 1'b0, 1'b0});
      pending_q.push_back(t);
    end
    if (!eom_has_byte || len == 0) pending_q.push_back('{8'($urandom), 1'b0, 1'b1});
  endfunction

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1;
  end

  // driver
  int   in_gap;
  int   out_gap;
  logic in_fire;
  initial begin
    in_gap = 0;
    out_gap = 0;
  end

  always @(posedge clk_i) begin
    in_fire <= rst_ni && in_valid_i && !in_stall_o;
  end

  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 0; data_byte_i <= 0; has_byte_i <= 0; end_of_message_i <= 0;
    end else if (in_fire) begin
      predict_digest('{data_byte_i, has_byte_i, end_of_message_i});
      in_gap = pick_gap();
      if (in_gap == 0 && pending_q.size() > 0) begin
        {data_byte_i, has_byte_i, end_of_message_i} <= pending_q.pop_front();
      end else begin
        in_valid_i <= 0;
      end
    end else if (!in_valid_i) begin
      if (in_gap > 0) in_gap--;
      else if (pending_q.size() > 0) begin
        {data_byte_i, has_byte_i, end_of_message_i} <= pending_q.pop_front();
        in_valid_i <= 1;
      end
    end
  end

  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 0;
    end else if (out_gap > 0) begin
      out_stall_i <= 1;
      out_gap--;
    end else begin
      out_stall_i <= 0;
      out_gap = pick_gap();
    end
  end

  // monitor
  always @(posedge clk_i) begin
    digest_txn_t exp_t;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (digest_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected digest transaction %h", digest_word_o);
      end else begin
        exp_t = digest_q.pop_front();
        if (exp_t.word !== digest_word_o || exp_t.idx !== word_index_o
            || exp_t.last !== last_word_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %h/%0d/%b got %h/%0d/%b", exp_t.word, exp_t.idx,
                     exp_t.last, digest_word_o, word_index_o, last_word_o);
        end
      end
    end
  end

  initial begin
    int len;
    mismatches = 0;
    hasher_reset();
    add_msg(0, -1, 0);
    add_msg(1, 0, 1);
    add_msg(2, 255, 0);
    add_msg(3, -1, 1);
    add_msg(57, -1, 1);
    add_msg(64, -1, 1);
    for (int m = 0; m < 4; m++) begin
      len = $urandom_range(0, 8);
      add_msg(len, -1, 1'($urandom_range(0, 1)));
    end
    wait (rst_ni);
    wait (pending_q.size() == 0);
    @(posedge clk_i);
    wait (!in_valid_i);
    wait (digest_q.size() == 0);
    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && digest_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("FAILURE");
    $finish;
  end
endmodule

/* files.f */
hw/rtl/sha1_pkg.sv
hw/rtl/sha1_ram.sv
hw/rtl/sha1_stream_hasher.sv
hw/rtl/sha1_checker.sv
dv/tb_sha1_stream_hasher.sv
